@@ rtl/core/dsfd_pkg.sv @@
// Shared types and constants for the serial frame decoder.
// No dependencies; imported by every module of the block.
`default_nettype none

package dsfd_pkg;

  // Frame geometry
  localparam int FRAME_BYTES   = 16;
  localparam int CHANNEL_SLOTS = 8;
  localparam int POS_W         = $clog2(FRAME_BYTES);
  localparam int CH_IDX_W      = (CHANNEL_SLOTS > 1) ? $clog2(CHANNEL_SLOTS) : 1;
  localparam int SLOT_COUNT    = (FRAME_BYTES - 2) / 2;
  localparam int SLOT_W        = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CNT_W         = 5;

  // Value and pulse widths
  localparam int CH_VAL_W = 11;
  localparam int PULSE_W  = 11;

  // Constants of the protocol
  localparam logic [15:0]        GAP_LIMIT_RESET = 16'd5000;
  localparam logic [PULSE_W-1:0] PULSE_DEFAULT   = 11'd1500;
  localparam logic [PULSE_W-1:0] PULSE_BASE      = 11'd988;
  localparam logic [2:0]         HI_MASK_HR      = 3'h7;
  localparam logic [2:0]         HI_MASK_LR      = 3'h3;

  // Item queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // Register indexes (byte address 4*i)
  localparam logic REG_HIGH_RES  = 1'b0;
  localparam logic REG_GAP_LIMIT = 1'b1;

  typedef enum logic {
    KIND_BYTE = 1'b0,
    KIND_READ = 1'b1
  } item_kind_e;

  typedef struct packed {
    item_kind_e  kind;
    logic [7:0]  rx_byte;
    logic [31:0] time_us;
    logic [3:0]  channel;
  } item_t;

  typedef struct packed {
    logic        high_res;
    logic [15:0] gap_limit;
  } cfg_t;

endpackage

`default_nettype wire

@@ rtl/core/dsm_serial_frame_decoder_top.sv @@
// Serial frame decoder, a received byte or a channel read per input transaction, one result
// for each. In the back end a byte is stored in state S_BYTE and a read is
// answered in state S_READ; when a complete frame is pending, a read first
// walks it into the channel store one two-byte slot at a time, each slot
// read through the registered read ports of the frame memory (S_DEC_RD) and
// then stored (S_DEC_WR). A two-entry queue in the front end keeps taking
// transactions while the back end works or while a result waits in the
// output register. Registers sit on the APB port at byte address 0 (high_resolution)
// and 4 (gap_limit_us). Depends on dsfd_pkg, dsfd_front and dsfd_back.
`default_nettype none

module dsm_serial_frame_decoder_top import dsfd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               mode_i,
  input  logic [7:0]         rx_byte_i,
  input  logic [31:0]        time_us_i,
  input  logic [3:0]         channel_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [PULSE_W-1:0] pulse_us_o,
  output logic               frame_ready_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  cfg_t  cfg_q, cfg_d;
  logic  reg_idx;
  logic  reg_wr;
  logic  item_valid;
  logic  item_ready;
  item_t item;

  // Register file
  assign pready  = 1'b1;
  assign reg_idx = paddr[2];
  assign reg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d = cfg_q;
    if (reg_wr) begin
      unique case (reg_idx)
        REG_HIGH_RES:  cfg_d.high_res  = pwdata[0];
        REG_GAP_LIMIT: cfg_d.gap_limit = pwdata[15:0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_HIGH_RES:  prdata = {31'b0, cfg_q.high_res};
      REG_GAP_LIMIT: prdata = {16'b0, cfg_q.gap_limit};
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.high_res  <= 1'b1;
      cfg_q.gap_limit <= GAP_LIMIT_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  dsfd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .mode_i       (mode_i),
    .rx_byte_i    (rx_byte_i),
    .time_us_i    (time_us_i),
    .channel_i    (channel_i),
    .item_valid_o (item_valid),
    .item_ready_i (item_ready),
    .item_o       (item)
  );

  dsfd_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .item_valid_i  (item_valid),
    .item_ready_o  (item_ready),
    .item_i        (item),
    .cfg_i         (cfg_q),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .pulse_us_o    (pulse_us_o),
    .frame_ready_o (frame_ready_o)
  );

endmodule

`default_nettype wire

@@ rtl/core/dsfd_front.sv @@
// Front end: accepts input transactions, classifies them and queues them.
// Depends on dsfd_pkg.
`default_nettype none

module dsfd_front import dsfd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        mode_i,
  input  logic [7:0]  rx_byte_i,
  input  logic [31:0] time_us_i,
  input  logic [3:0]  channel_i,
  output logic        item_valid_o,
  input  logic        item_ready_i,
  output item_t       item_o
);

  item_t               queue_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QPTR_W:0]     count_q, count_d;
  logic                push, pop;
  item_t               new_item;

  // Classify the incoming transaction
  always_comb begin
    new_item.kind    = item_kind_e'(mode_i);
    new_item.rx_byte = rx_byte_i;
    new_item.time_us = time_us_i;
    new_item.channel = channel_i;
  end

  assign in_ready_o   = (count_q != (QPTR_W+1)'(QUEUE_DEPTH));
  assign item_valid_o = (count_q != '0);
  assign item_o       = queue_q[rd_ptr_q];

  assign push = in_valid_i && in_ready_o;
  assign pop  = item_valid_o && item_ready_i;

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= new_item;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/dsfd_back.sv @@
// Back end: stores bytes, walks a pending frame into the channel store and
// answers channel reads through an output register. Depends on dsfd_pkg.
`default_nettype none

module dsfd_back import dsfd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               item_valid_i,
  output logic               item_ready_o,
  input  item_t              item_i,
  input  cfg_t               cfg_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [PULSE_W-1:0] pulse_us_o,
  output logic               frame_ready_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_BYTE,
    S_DEC_RD,
    S_DEC_WR,
    S_READ
  } state_e;

  state_e               state_q, state_d;
  item_t                item_q, item_d;
  logic [POS_W-1:0]     pos_q, pos_d;
  logic [31:0]          last_time_q, last_time_d;
  logic                 pend_q, pend_d;
  logic                 seen_q, seen_d;
  logic [SLOT_W-1:0]    slot_q, slot_d;
  logic [CH_VAL_W-1:0]  chan_q [CHANNEL_SLOTS];
  logic [CH_VAL_W-1:0]  chan_d [CHANNEL_SLOTS];
  logic                 out_valid_q, out_valid_d;
  logic [PULSE_W-1:0]   pulse_q, pulse_d;
  logic                 fr_q, fr_d;

  // Frame memory, undefined until written
  logic [7:0]           frame_mem [FRAME_BYTES];
  logic [7:0]           rd_hi_q, rd_lo_q;
  logic [POS_W-1:0]     addr_hi, addr_lo;
  logic                 mem_we;

  logic                 out_free;
  logic [31:0]          gap;
  logic                 long_gap;
  logic [POS_W-1:0]     pos_eff;
  logic                 at_last;
  logic [CNT_W-1:0]     ch_count;
  logic [3:0]           slot_id;
  logic                 slot_ok;
  logic [CH_VAL_W-1:0]  slot_val;
  logic [CH_VAL_W-1:0]  ch_val;
  logic                 ch_ok;
  logic [PULSE_W-1:0]   read_pulse;

  assign item_ready_o  = (state_q == S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign pulse_us_o    = pulse_q;
  assign frame_ready_o = fr_q;
  assign out_free      = !out_valid_q || out_ready_i;

  // Byte position with wrapping gap check
  assign gap      = item_q.time_us - last_time_q;
  assign long_gap = gap > {16'b0, cfg_i.gap_limit};
  assign pos_eff  = long_gap ? '0 : pos_q;
  assign at_last  = (pos_eff == POS_W'(FRAME_BYTES - 1));
  assign mem_we   = (state_q == S_BYTE) && out_free;

  // Slot s occupies bytes 2+2s and 3+2s
  assign addr_hi = POS_W'({slot_q, 1'b0}) + POS_W'(2);
  assign addr_lo = {addr_hi[POS_W-1:1], 1'b1};

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      frame_mem[pos_eff] <= item_q.rx_byte;
    end
    rd_hi_q <= frame_mem[addr_hi];
    rd_lo_q <= frame_mem[addr_lo];
  end

  // Slot decode, following the resolution mode
  assign ch_count = cfg_i.high_res ? CNT_W'(CHANNEL_SLOTS) : CNT_W'(CHANNEL_SLOTS - 1);
  assign slot_id  = cfg_i.high_res ? rd_hi_q[6:3] : rd_hi_q[5:2];
  assign slot_ok  = CNT_W'(slot_id) < ch_count;
  assign slot_val = cfg_i.high_res ? {rd_hi_q[2:0] & HI_MASK_HR, rd_lo_q}
                                   : {rd_hi_q[2:0] & HI_MASK_LR, rd_lo_q};

  // Read answer
  assign ch_val     = chan_q[item_q.channel[CH_IDX_W-1:0]];
  assign ch_ok      = (CNT_W'(item_q.channel) < ch_count) && seen_q;
  assign read_pulse = !ch_ok ? PULSE_DEFAULT
                    : PULSE_BASE + (cfg_i.high_res ? {1'b0, ch_val[CH_VAL_W-1:1]} : ch_val);

  // Next-state logic
  always_comb begin
    state_d     = state_q;
    item_d      = item_q;
    pos_d       = pos_q;
    last_time_d = last_time_q;
    pend_d      = pend_q;
    seen_d      = seen_q;
    slot_d      = slot_q;
    chan_d      = chan_q;
    out_valid_d = out_valid_q && !out_ready_i;
    pulse_d     = pulse_q;
    fr_d        = fr_q;
    unique case (state_q)
      S_IDLE: begin
        if (item_valid_i) begin
          item_d = item_i;
          slot_d = '0;
          if (item_i.kind == KIND_BYTE) begin
            state_d = S_BYTE;
          end else if (pend_q) begin
            state_d = S_DEC_RD;
          end else begin
            state_d = S_READ;
          end
        end
      end
      S_BYTE: begin
        if (out_free) begin
          last_time_d = item_q.time_us;
          seen_d      = 1'b1;
          if (at_last) begin
            pend_d = 1'b1;
            pos_d  = pos_eff;
          end else begin
            pos_d  = pos_eff + 1'b1;
          end
          out_valid_d = 1'b1;
          pulse_d     = '0;
          fr_d        = at_last || pend_q;
          state_d     = S_IDLE;
        end
      end
      S_DEC_RD: begin
        state_d = S_DEC_WR;
      end
      S_DEC_WR: begin
        if (slot_ok) begin
          chan_d[slot_id[CH_IDX_W-1:0]] = slot_val;
        end
        if (slot_q == SLOT_W'(SLOT_COUNT - 1)) begin
          pend_d  = 1'b0;
          state_d = S_READ;
        end else begin
          slot_d  = slot_q + 1'b1;
          state_d = S_DEC_RD;
        end
      end
      S_READ: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          pulse_d     = read_pulse;
          fr_d        = pend_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State and output registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      item_q      <= '0;
      pos_q       <= '0;
      last_time_q <= '0;
      pend_q      <= 1'b0;
      seen_q      <= 1'b0;
      slot_q      <= '0;
      for (int i = 0; i < CHANNEL_SLOTS; i++) begin
        chan_q[i] <= '0;
      end
      out_valid_q <= 1'b0;
      pulse_q     <= '0;
      fr_q        <= 1'b0;
    end else begin
      state_q     <= state_d;
      item_q      <= item_d;
      pos_q       <= pos_d;
      last_time_q <= last_time_d;
      pend_q      <= pend_d;
      seen_q      <= seen_d;
      slot_q      <= slot_d;
      chan_q      <= chan_d;
      out_valid_q <= out_valid_d;
      pulse_q     <= pulse_d;
      fr_q        <= fr_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/dsfd_checker.sv @@
// Port-level checks for the serial frame decoder, bound to the top level.
// Depends on dsfd_pkg and dsm_serial_frame_decoder_top.
`default_nettype none

module dsfd_checker import dsfd_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic [PULSE_W-1:0] pulse_us_o,
  input logic               frame_ready_o
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(pulse_us_o)
                                    && $stable(frame_ready_o))
    else $error("result changed while stalled");

  // A read answer never leaves a frame pending
  a_read_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (pulse_us_o != '0) |-> !frame_ready_o)
    else $error("frame still pending after a read");

  // Nothing is offered while reset is held
  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_o && !frame_ready_o)
    else $error("result shown during reset");

endmodule

bind dsm_serial_frame_decoder_top dsfd_checker u_dsfd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .pulse_us_o    (pulse_us_o),
  .frame_ready_o (frame_ready_o)
);

`default_nettype wire

@@ bench/tb.sv @@
`timescale 1ns / 100ps
// Testbench for dsm_serial_frame_decoder_top: byte and channel-read transactions checked
// against an in-bench frame decoder, with random idling on both channels.
// Depends on dsfd_pkg and the RTL of the block; reads no files.

module tb;
  import dsfd_pkg::*;

  localparam int CLK_PERIOD     = 8;
  localparam int RESET_CYCLES   = 9;
  localparam int MAX_IDLE       = 5;
  localparam int SETTLE_CYCLES  = 24;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_ITEMS   = 1400;

  // Frame with channel 0 at its largest value, channel 1 at zero and two dropped ids
  localparam logic [7:0] DIRECTED_FRAME [FRAME_BYTES] = '{
    8'h00, 8'hFF,
    8'h87, 8'hFF,
    8'h08, 8'h00,
    8'h3D, 8'h55,
    8'h7A, 8'hAA,
    8'h43, 8'h12,
    8'h1C, 8'h00,
    8'h12, 8'h34
  };
  localparam logic [3:0] DIRECTED_READS [6] = '{4'd0, 4'd1, 4'd2, 4'd7, 4'd8, 4'd15};

  typedef struct packed {
    logic [PULSE_W-1:0] pulse;
    logic               frame_ready;
  } decoded_t;

  // DUT ports
  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic               mode_i;
  logic [7:0]         rx_byte_i;
  logic [31:0]        time_us_i;
  logic [3:0]         channel_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [PULSE_W-1:0] pulse_us_o;
  logic               frame_ready_o;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [2:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  // Decoder state as the bench sees it
  cfg_t                cur_cfg;
  logic [7:0]          rx_frame [FRAME_BYTES];
  int unsigned         rx_pos;
  logic [31:0]         rx_last_time;
  logic                frame_pending;
  logic                any_byte_seen;
  logic [CH_VAL_W-1:0] channel_values [CHANNEL_SLOTS];

  decoded_t    expected_decodes [$];
  int unsigned mismatch_count = 0;
  int unsigned sent_items     = 0;
  int unsigned quiet_cycles   = 0;
  logic [31:0] stamp_now      = '0;
  logic        idle_enable    = 1'b1;
  logic        hold_request   = 1'b0;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  dsm_serial_frame_decoder_top i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .mode_i        (mode_i),
    .rx_byte_i     (rx_byte_i),
    .time_us_i     (time_us_i),
    .channel_i     (channel_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .pulse_us_o    (pulse_us_o),
    .frame_ready_o (frame_ready_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // Work out the result of one accepted transaction and queue it
  function automatic void predict_decode(input item_t it);
    logic [31:0] gap;
    logic [7:0]  hi;
    logic [3:0]  id;
    logic [2:0]  mask;
    int unsigned count;
    int unsigned sum;
    decoded_t    res;
    count     = cur_cfg.high_res ? CHANNEL_SLOTS : CHANNEL_SLOTS - 1;
    res.pulse = '0;
    if (it.kind == KIND_BYTE) begin
      // wrapping gap; a long one restarts the frame
      gap           = it.time_us - rx_last_time;
      rx_last_time  = it.time_us;
      any_byte_seen = 1'b1;
      if (gap > 32'(cur_cfg.gap_limit)) rx_pos = 0;
      rx_frame[rx_pos] = it.rx_byte;
      if (rx_pos == FRAME_BYTES - 1) frame_pending = 1'b1;
      else rx_pos++;
    end else begin
      // pending frame is decoded with the resolution in force at the read
      if (frame_pending) begin
        mask = cur_cfg.high_res ? HI_MASK_HR : HI_MASK_LR;
        for (int b = 3; b < FRAME_BYTES; b += 2) begin
          hi = rx_frame[b-1];
          id = cur_cfg.high_res ? hi[6:3] : hi[5:2];
          if (id < count) channel_values[id] = {hi[2:0] & mask, rx_frame[b]};
        end
        frame_pending = 1'b0;
      end
      if (it.channel >= count || !any_byte_seen) begin
        res.pulse = PULSE_DEFAULT;
      end else begin
        sum = PULSE_BASE + (cur_cfg.high_res ? channel_values[it.channel] >> 1
                                             : channel_values[it.channel]);
        res.pulse = sum[PULSE_W-1:0];
      end
    end
    res.frame_ready = frame_pending;
    expected_decodes.push_back(res);
  endfunction

  function automatic logic [3:0] pick_channel();
    return ($urandom_range(0, 4) == 0) ? 4'($urandom)
                                       : 4'($urandom_range(0, CHANNEL_SLOTS - 1));
  endfunction

  // One input transaction; valid stays up across back-to-back items
  task automatic send_item(input item_kind_e kind, input logic [7:0] data,
                           input logic [31:0] stamp, input logic [3:0] ch);
    int unsigned idle;
    item_t       it;
    idle = idle_enable ? $urandom_range(0, MAX_IDLE) : 0;
    if (idle != 0) begin
      in_valid_i <= 1'b0;
      repeat (idle) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i     <= kind;
    rx_byte_i  <= data;
    time_us_i  <= stamp;
    channel_i  <= ch;
    do @(posedge clk_i); while (!in_ready_o);
    it = '{kind: kind, rx_byte: data, time_us: stamp, channel: ch};
    predict_decode(it);
    sent_items++;
  endtask

  task automatic send_byte(input logic [7:0] data, input logic [31:0] gap);
    stamp_now += gap;
    send_item(KIND_BYTE, data, stamp_now, 4'($urandom));
  endtask

  task automatic send_read(input logic [3:0] ch);
    send_item(KIND_READ, 8'($urandom), $urandom, ch);
  endtask

  // Bytes of a frame; slot first bytes mostly carry an id the current mode accepts
  task automatic send_frame(input int unsigned n_bytes, input logic restart);
    logic [31:0] gap;
    logic [7:0]  data;
    logic [3:0]  id;
    for (int unsigned p = 0; p < n_bytes; p++) begin
      data = $urandom;
      if (p >= 2 && p % 2 == 0 && $urandom_range(0, 7) != 0) begin
        id = ($urandom_range(0, 5) == 0) ? 4'($urandom_range(8, 15))
                                         : 4'($urandom_range(0, 7));
        if (cur_cfg.high_res) data[6:3] = id;
        else data[5:2] = id;
      end
      if (p == 0 && restart) gap = 32'(cur_cfg.gap_limit) + 1 + $urandom_range(0, 100000);
      else gap = $urandom_range(0, cur_cfg.gap_limit);
      send_byte(data, gap);
    end
  endtask

  // Wait until every result is back and the block has gone quiet
  task automatic settle();
    in_valid_i <= 1'b0;
    while (expected_decodes.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Setup and access phase; psel is left high for a following write
  task automatic write_reg(input logic idx, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (idx == REG_HIGH_RES) cur_cfg.high_res = data[0];
    else cur_cfg.gap_limit = data[15:0];
  endtask

  task automatic apply_config(input logic high_res, input logic [15:0] gap_limit);
    settle();
    write_reg(REG_HIGH_RES, {31'd0, high_res});
    write_reg(REG_GAP_LIMIT, {16'd0, gap_limit});
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // One random stretch of traffic: mostly whole frames, some broken ones, some noise
  task automatic send_sequence();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      send_frame(FRAME_BYTES + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0),
                 $urandom_range(0, 9) != 0);
      repeat ($urandom_range(0, 3)) send_read(pick_channel());
    end else if (pick < 85) begin
      send_frame($urandom_range(1, FRAME_BYTES - 1), $urandom_range(0, 3) != 0);
      if ($urandom_range(0, 1) != 0) send_read(pick_channel());
    end else begin
      repeat ($urandom_range(1, 6)) begin
        if ($urandom_range(0, 1) != 0) begin
          stamp_now = $urandom;
          send_byte(8'($urandom), 32'd0);
        end else begin
          send_read(4'($urandom));
        end
      end
    end
  endtask

  // Reads before data, one full frame across the timestamp wrap, an overwrite of
  // the last slot, then reads of good, dropped and out-of-range channels
  task automatic test_directed();
    send_read(4'd0);
    send_read(4'd15);
    stamp_now = 32'hFFFF_FE00;
    for (int i = 0; i < FRAME_BYTES; i++) begin
      send_byte(DIRECTED_FRAME[i], (i == 0) ? 32'd0 : 32'd100);
    end
    send_byte(8'h99, 32'd100);
    for (int i = 0; i < 6; i++) send_read(DIRECTED_READS[i]);
  endtask

  // Both resolutions at the smallest and largest gap limits, default (low), random (high);
  // first reads of a phase see values stored under the previous mode unless a frame pends
  task automatic test_register_sweep();
    logic [15:0] limits [6];
    limits = '{16'd0, 16'd0, 16'hFFFF, 16'hFFFF, GAP_LIMIT_RESET, 16'($urandom)};
    for (int i = 0; i < 6; i++) begin
      apply_config(1'(i % 2), limits[i]);
      send_read(pick_channel());
      send_read(pick_channel());
      repeat (3) send_sequence();
    end
  endtask

  // Long random run with occasional setting changes and one long output hold-off
  task automatic test_random_traffic();
    int unsigned first;
    int unsigned block;
    first = sent_items;
    block = 0;
    while (sent_items - first < RANDOM_ITEMS) begin
      if (block % 8 == 7) begin
        apply_config(1'($urandom_range(0, 1)),
                     ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                 : 16'($urandom_range(200, 8000)));
      end
      idle_enable = ($urandom_range(0, 3) != 0);
      if (block == 5) hold_request = 1'b1;
      repeat (4) send_sequence();
      block++;
    end
    idle_enable = 1'b1;
  endtask

  // Result side: random ready, one long hold-off on request, field checks
  initial begin : result_sink
    int unsigned idle;
    decoded_t    want;
    out_ready_i <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (hold_request) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_request = 1'b0;
      end
      idle = idle_enable ? $urandom_range(0, MAX_IDLE) : 0;
      if (idle != 0) begin
        out_ready_i <= 1'b0;
        repeat (idle) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      if (expected_decodes.size() == 0) begin
        $display("%0t: result with no transaction waiting, pulse_us %0d frame_ready %0b",
                 $time, pulse_us_o, frame_ready_o);
        mismatch_count++;
      end else begin
        want = expected_decodes.pop_front();
        if (pulse_us_o !== want.pulse) begin
          $display("%0t: pulse_us expected %0d, actual %0d", $time, want.pulse, pulse_us_o);
          mismatch_count++;
        end
        if (frame_ready_o !== want.frame_ready) begin
          $display("%0t: frame_ready expected %0b, actual %0b",
                   $time, want.frame_ready, frame_ready_o);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: too long without any transaction on any port
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    mode_i     <= KIND_BYTE;
    rx_byte_i  <= '0;
    time_us_i  <= '0;
    channel_i  <= '0;
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    paddr      <= '0;
    pwdata     <= '0;
    cur_cfg       = '{high_res: 1'b1, gap_limit: GAP_LIMIT_RESET};
    rx_pos        = 0;
    rx_last_time  = '0;
    frame_pending = 1'b0;
    any_byte_seen = 1'b0;
    foreach (rx_frame[i]) rx_frame[i] = '0;
    foreach (channel_values[i]) channel_values[i] = '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_register_sweep();
    test_random_traffic();
    settle();

    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

@@ dsm_serial_frame_decoder_top.f @@
rtl/core/dsfd_pkg.sv
rtl/core/dsfd_front.sv
rtl/core/dsfd_back.sv
rtl/core/dsm_serial_frame_decoder_top.sv
rtl/core/dsfd_checker.sv
bench/tb.sv
